>>> rtl/grow_light_photoperiod_controller_assert.svh
// Assertion macros shared by the checker of the grow light photoperiod controller
`ifndef GROW_LIGHT_PHOTOPERIOD_CONTROLLER_ASSERT_SVH
`define GROW_LIGHT_PHOTOPERIOD_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define GLPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glpc assertion failed");

// next-cycle implication
`define GLPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glpc assertion failed");

`endif

>>> rtl/glpc_pkg.sv
// Types, constants and arithmetic helpers of the grow light photoperiod controller
package glpc_pkg;

    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_HIGH = 2'd1;
    localparam logic [1:0] MODE_LOW  = 2'd2;
    localparam logic [1:0] MODE_MUTE = 2'd3;

    localparam logic [1:0] CFG_DAY_MINUTES = 2'd0;
    localparam logic [1:0] CFG_LED_MAX     = 2'd1;
    localparam logic [1:0] CFG_GROW_MODE   = 2'd2;
    localparam logic [1:0] CFG_MIN_DUTY    = 2'd3;

    localparam logic [10:0] DAY_MINUTES_RST = 11'd1080;
    localparam logic [7:0]  LED_MAX_RST     = 8'd100;
    localparam logic [7:0]  MIN_DUTY_RST    = 8'd20;

    localparam logic signed [12:0] DAY_LEN      = 13'sd1440;
    localparam logic signed [12:0] RAMP_MINUTES = 13'sd10;
    localparam logic [3:0]  DIM_MINUTES  = 4'd15;
    localparam logic [31:0] BTN_MIN_GAP  = 32'd300;
    localparam logic [31:0] BTN_MUTE_GAP = 32'd600;
    localparam logic [10:0] PERIOD_MAX   = 11'd2047;
    localparam logic [15:0] DAYS_MAX     = 16'hFFFF;

    // 255 * ceil(2^24 / 133); exact floor(p * 255 / 133) for 8-bit p
    localparam logic [24:0] MAX_DUTY_MUL = 25'd32166975;

    typedef struct packed {
        logic        opcode;
        logic        button_down;
        logic [31:0] now_ms;
        logic        ignore_day_count;
    } in_t;

    typedef struct packed {
        logic [7:0]  pwm_duty;
        logic        lamp_on;
        logic [1:0]  lamp_mode;
        logic        is_daytime;
        logic [10:0] minutes_elapsed;
        logic [15:0] day_counter;
    } out_t;

    typedef struct packed {
        logic [10:0] day_minutes;
        logic [7:0]  max_duty;
        logic        grow_mode;
        logic [7:0]  min_duty;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  duty;
        logic        enable;
        logic        day_flag;
        logic [10:0] period;
        logic [15:0] days;
        logic [3:0]  dim_left;
        logic        pending;
        logic [31:0] last_ms;
    } state_t;

    function automatic logic [7:0] max_duty_f(input logic [7:0] pct);
        logic [32:0] prod;
        logic [8:0]  q;
        begin
            prod = 33'(pct) * 33'(MAX_DUTY_MUL);
            q    = prod[32:24];
            max_duty_f = q[8] ? 8'hFF : q[7:0];
        end
    endfunction

    // k * ceil(2^16 / 10); exact floor(x * k / 10) for x below 256
    function automatic logic [16:0] ramp_coef_f(input logic [3:0] k);
        begin
            ramp_coef_f = 17'(k) * 17'd6554;
        end
    endfunction

endpackage

>>> rtl/grow_light_photoperiod_controller.sv
// Top level of the grow light photoperiod controller
//
// s_ channel: one beat per event, opcode 0 is a one-minute tick, opcode 1 a
// sample of the dimmer button (level plus millisecond time stamp).
// m_ channel: exactly one result beat per input beat, in order, showing the
// lamp duty, enable, mode, phase, minutes in phase and day count after the event.
// cfg port: cfg_wr_en writes cfg_wdata to register cfg_addr;
// 0 day length, 1 max brightness (turned into a duty at write time),
// 2 grow/drying mode, 3 minimum duty. Write only while no beat is in flight.
// Each input beat is taken into the input register, then the combinational
// next-state logic writes the state and result registers.
// Throughput: one beat per cycle while the m_ side is not stalled.
// A stalled m_ side holds the result; one more input beat is taken into the
// input register, after which s_ready drops until the result is taken.
// Reset: synchronous, active low; clears both pipeline valids, sets the
// registers to day length 1080, brightness 100, grow mode, min duty 20,
// lamp OFF, day phase, all counters zero.
module grow_light_photoperiod_controller (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  glpc_pkg::in_t    s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output glpc_pkg::out_t   m_data,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_addr,
    input  logic [10:0]      cfg_wdata
);
    import glpc_pkg::*;

    cfg_t   cfg_reg;
    state_t st_reg;
    state_t st_next;
    in_t    in_reg;
    logic   in_valid_reg;
    out_t   out_reg;
    logic   out_valid_reg;
    logic   out_free;
    logic   advance;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    glpc_step u_step (
        .cfg     (cfg_reg),
        .st      (st_reg),
        .item    (in_reg),
        .st_next (st_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            cfg_reg.day_minutes <= DAY_MINUTES_RST;
            cfg_reg.max_duty    <= max_duty_f(LED_MAX_RST);
            cfg_reg.grow_mode   <= 1'b1;
            cfg_reg.min_duty    <= MIN_DUTY_RST;
            st_reg.mode         <= MODE_OFF;
            st_reg.duty         <= '0;
            st_reg.enable       <= 1'b0;
            st_reg.day_flag     <= 1'b1;
            st_reg.period       <= '0;
            st_reg.days         <= '0;
            st_reg.dim_left     <= '0;
            st_reg.pending      <= 1'b0;
            st_reg.last_ms      <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_DAY_MINUTES: cfg_reg.day_minutes <= cfg_wdata;
                    CFG_LED_MAX:     cfg_reg.max_duty    <= max_duty_f(cfg_wdata[7:0]);
                    CFG_GROW_MODE:   cfg_reg.grow_mode   <= cfg_wdata[0];
                    CFG_MIN_DUTY:    cfg_reg.min_duty    <= cfg_wdata[7:0];
                endcase
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance) begin
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg.pwm_duty        <= st_next.duty;
            out_reg.lamp_on         <= st_next.enable;
            out_reg.lamp_mode       <= st_next.mode;
            out_reg.is_daytime      <= st_next.day_flag;
            out_reg.minutes_elapsed <= st_next.period;
            out_reg.day_counter     <= st_next.days;
        end
    end

endmodule

>>> rtl/glpc_step.sv
// Next-state logic for one tick or button beat
module glpc_step (
    input  glpc_pkg::cfg_t   cfg,
    input  glpc_pkg::state_t st,
    input  glpc_pkg::in_t    item,
    output glpc_pkg::state_t st_next
);
    import glpc_pkg::*;

    function automatic state_t set_light(input state_t s, input logic [1:0] mode,
                                         input cfg_t c);
        state_t r;
        begin
            r = s;
            unique case (mode)
                MODE_HIGH: begin
                    r.duty   = c.max_duty;
                    r.enable = 1'b1;
                end
                MODE_LOW: begin
                    if (c.min_duty < c.max_duty) begin
                        r.duty   = c.min_duty;
                        r.enable = 1'b1;
                    end
                    r.dim_left = DIM_MINUTES;
                end
                default: begin
                    r.enable = 1'b0;
                end
            endcase
            r.mode = mode;
            set_light = r;
        end
    endfunction

    logic signed [12:0] m_s;
    logic signed [12:0] day_s;
    logic signed [12:0] night_s;
    logic signed [12:0] ramp_pos;
    logic [11:0]        m_u;
    logic [3:0]         k;
    logic               sunrise;
    logic               do_ramp;
    logic               restart;
    logic signed [9:0]  span;
    logic [7:0]         span_abs;
    logic [24:0]        prod;
    logic [7:0]         q;
    logic [31:0]        gap;
    state_t             s;

    always_comb begin
        s        = st;
        m_u      = {1'b0, st.period} + 12'd1;
        m_s      = 13'(m_u);
        day_s    = 13'(cfg.day_minutes);
        night_s  = DAY_LEN - day_s;
        ramp_pos = '0;
        sunrise  = 1'b0;
        do_ramp  = 1'b0;
        restart  = 1'b0;
        gap      = item.now_ms - st.last_ms;

        if (!item.opcode) begin
            if (s.mode == MODE_LOW) begin
                s.dim_left = s.dim_left - 4'd1;
                if (s.dim_left == 4'd0) begin
                    s = set_light(s, MODE_HIGH, cfg);
                end
            end
            if (s.day_flag) begin
                if (m_s > day_s) begin
                    s = set_light(s, MODE_OFF, cfg);
                    s.day_flag = 1'b0;
                    restart = 1'b1;
                end else if (m_s >= day_s - RAMP_MINUTES && s.mode == MODE_HIGH) begin
                    do_ramp  = 1'b1;
                    ramp_pos = m_s - day_s + RAMP_MINUTES;
                end
            end else if (cfg.grow_mode) begin
                if (m_s > night_s) begin
                    if (!item.ignore_day_count && s.days != DAYS_MAX) begin
                        s.days = s.days + 16'd1;
                    end
                    s = set_light(s, MODE_HIGH, cfg);
                    s.day_flag = 1'b1;
                    restart = 1'b1;
                end else if (m_s >= night_s - RAMP_MINUTES && s.mode == MODE_OFF) begin
                    do_ramp  = 1'b1;
                    sunrise  = 1'b1;
                    ramp_pos = m_s - night_s + RAMP_MINUTES;
                end
            end else if (m_s > night_s) begin
                if (s.days != DAYS_MAX) begin
                    s.days = s.days + 16'd1;
                end
                restart = 1'b1;
            end
        end

        // ramp: span * k / 10, truncated toward zero
        k        = ramp_pos[3:0];
        span     = 10'(cfg.max_duty) - 10'(cfg.min_duty);
        span_abs = span[9] ? 8'(-span) : span[7:0];
        prod     = 25'(span_abs) * 25'(ramp_coef_f(k));
        q        = prod[23:16];

        if (!item.opcode) begin
            if (do_ramp) begin
                if (sunrise) begin
                    s.duty = span[9] ? cfg.min_duty - q : cfg.min_duty + q;
                end else begin
                    s.duty = span[9] ? cfg.max_duty + q : cfg.max_duty - q;
                end
                s.enable = 1'b1;
            end
            if (restart) begin
                s.period = '0;
            end else begin
                s.period = m_u[11] ? PERIOD_MAX : m_u[10:0];
            end
        end else if (item.button_down) begin
            s.pending = 1'b1;
        end else if (s.pending && gap > BTN_MIN_GAP) begin
            s.last_ms = item.now_ms;
            s.pending = 1'b0;
            if (gap <= BTN_MUTE_GAP && s.mode == MODE_LOW) begin
                s = set_light(s, MODE_MUTE, cfg);
            end else if (s.mode == MODE_HIGH) begin
                s = set_light(s, MODE_LOW, cfg);
            end else if (s.mode == MODE_LOW || s.mode == MODE_MUTE) begin
                s = set_light(s, MODE_HIGH, cfg);
            end
        end

        st_next = s;
    end

endmodule

>>> rtl/glpc_checker.sv
// Port-level checker of the grow light photoperiod controller and its bind
`include "grow_light_photoperiod_controller_assert.svh"

module glpc_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_ready,
    input glpc_pkg::out_t m_data,
    input logic           m_valid,
    input logic           m_ready
);
    import glpc_pkg::*;

    // a stalled result beat holds
    `GLPC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // input side only backs up behind a waiting result
    `GLPC_ASSERT_NOW(a_ready_stall, aclk, aresetn, !s_ready, m_valid && !m_ready)

    `GLPC_ASSERT_NOW(a_high_lit, aclk, aresetn, m_valid && m_data.lamp_mode == MODE_HIGH, m_data.lamp_on)

    `GLPC_ASSERT_NOW(a_mute_dark, aclk, aresetn, m_valid && m_data.lamp_mode == MODE_MUTE, !m_data.lamp_on)

endmodule

bind grow_light_photoperiod_controller glpc_checker u_glpc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_data  (m_data),
    .m_valid (m_valid),
    .m_ready (m_ready)
);
